@@ rtl/cbcc_pkg.sv @@
// Package with shared types and constants for the clock block cache controller.
package cbcc_pkg;

  localparam int IdxW  = 20;
  localparam int BsW   = 9;
  localparam int TotW  = 21;
  localparam int LenW  = 16;
  localparam int OffW  = 12;

  // Configuration register indexes.
  localparam logic [1:0] CfgBlockSize    = 2'd0;
  localparam logic [1:0] CfgTotalRecords = 2'd1;
  localparam logic [1:0] CfgRecordLength = 2'd2;

  // Request passed from the front part to the back part.
  typedef struct packed {
    logic [IdxW-1:0] record_index;
    logic [IdxW-1:0] block_id;
    logic [BsW-1:0]  bs;
  } cbcc_req_t;

  // Divider states.
  typedef enum logic [1:0] {DIV_IDLE, DIV_RUN, DIV_DONE} cbcc_div_state_t;

  // Back part states.
  typedef enum logic [2:0] {
    BK_IDLE, BK_LOOK, BK_WALK, BK_CALC, BK_OFFS, BK_OUT
  } cbcc_bk_state_t;

  // Clamp the block size register to 1..256.
  function automatic logic [BsW-1:0] eff_bs(input logic [BsW-1:0] v);
    if (v == '0) return 9'd1;
    if (v > 9'd256) return 9'd256;
    return v;
  endfunction

endpackage

@@ rtl/cbcc_front.sv @@
// Front part: accepts a request and computes its block number with a radix-2 divider.
module cbcc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [19:0]         in_record_index,
  input  logic [8:0]          bs_cfg,
  output logic                q_push,
  output cbcc_pkg::cbcc_req_t q_data,
  input  logic                q_full
);
  import cbcc_pkg::*;

  cbcc_div_state_t st_r, st_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic [IdxW-1:0] quo_r, quo_nxt;
  logic [BsW-1:0]  rem_r, rem_nxt;
  logic [BsW-1:0]  bs_r, bs_nxt;
  logic [4:0]      cnt_r, cnt_nxt;
  logic [BsW:0]    trial;

  // State and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= DIV_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    idx_r <= idx_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    bs_r  <= bs_nxt;
    cnt_r <= cnt_nxt;
  end

  // One quotient bit per cycle, most significant first.
  always_comb begin
    st_nxt  = st_r;
    idx_nxt = idx_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    bs_nxt  = bs_r;
    cnt_nxt = cnt_r;
    in_stall = (st_r != DIV_IDLE);
    q_push = 1'b0;
    trial = {rem_r, quo_r[IdxW-1]};
    unique case (st_r)
      DIV_IDLE: begin
        if (in_valid) begin
          idx_nxt = in_record_index;
          quo_nxt = in_record_index;
          rem_nxt = '0;
          bs_nxt  = eff_bs(bs_cfg);
          cnt_nxt = 5'd0;
          st_nxt  = DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (trial >= {1'b0, bs_r}) begin
          rem_nxt = BsW'(trial - {1'b0, bs_r});
          quo_nxt = {quo_r[IdxW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[BsW-1:0];
          quo_nxt = {quo_r[IdxW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(IdxW-1)) st_nxt = DIV_DONE;
      end
      DIV_DONE: begin
        if (!q_full) begin
          q_push = 1'b1;
          st_nxt = DIV_IDLE;
        end
      end
      default: st_nxt = DIV_IDLE;
    endcase
  end

  assign q_data = '{record_index: idx_r, block_id: quo_r, bs: bs_r};
endmodule

@@ rtl/cbcc_queue.sv @@
// Two-entry request queue between the front and back parts.
module cbcc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cbcc_pkg::cbcc_req_t push_data,
  output logic                full,
  input  logic                pop,
  output cbcc_pkg::cbcc_req_t pop_data,
  output logic                not_empty
);
  import cbcc_pkg::*;

  cbcc_req_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  assign full = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data = mem_r[rp_r];
endmodule

@@ rtl/cbcc_back.sv @@
// Back part: tag lookup, CLOCK victim walk, fill range and offset, result register.
module cbcc_back #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  cbcc_pkg::cbcc_req_t q_data,
  output logic                q_pop,
  input  logic [20:0]         total_records,
  input  logic [15:0]         record_length,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_hit,
  output logic [3:0]          out_slot,
  output logic [19:0]         out_block_id,
  output logic                out_evict_valid,
  output logic [19:0]         out_evicted_block,
  output logic [19:0]         out_fill_first,
  output logic [8:0]          out_fill_count,
  output logic [11:0]         out_storage_offset,
  output logic [15:0]         out_returned_length
);
  import cbcc_pkg::*;
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  cbcc_bk_state_t st_r, st_nxt;
  logic [IdxW-1:0] tag_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld_r, vld_nxt, ref_r, ref_nxt;
  logic [SW-1:0] hand_r, hand_nxt;
  cbcc_req_t req_r, req_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic hit_r, hit_nxt;
  logic ev_r, ev_nxt;
  logic [IdxW-1:0] evb_r, evb_nxt;
  logic [IdxW-1:0] start_r, start_nxt;
  logic [BsW-1:0] fc_r, fc_nxt;
  logic [OffW-1:0] off_r, off_nxt;
  logic inr_r, inr_nxt;
  logic tag_we;

  // Match vector and first matching slot.
  logic [NUM_SLOTS-1:0] match;
  logic [SW-1:0] match_idx;
  logic any_match;
  always_comb begin
    match_idx = '0;
    any_match = 1'b0;
    for (int i = NUM_SLOTS-1; i >= 0; i--) begin
      match[i] = vld_r[i] && (tag_r[i] == req_r.block_id);
      if (match[i]) begin
        match_idx = SW'(i);
        any_match = 1'b1;
      end
    end
  end

  logic [IdxW+BsW-1:0] prod;
  logic [TotW:0] endv;
  logic [TotW:0] endc;
  logic [SW+BsW-1:0] sprod;
  logic [SW-1:0] hand_inc;
  assign prod = req_r.block_id * req_r.bs;
  assign endv = {1'b0, {1'b0, start_r}} + {{(TotW+1-BsW){1'b0}}, req_r.bs};
  assign endc = (endv > {1'b0, total_records}) ? {1'b0, total_records} : endv;
  assign sprod = slot_r * req_r.bs;
  assign hand_inc = (hand_r == SW'(NUM_SLOTS-1)) ? '0 : hand_r + SW'(1);

  // Control and bookkeeping registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      vld_r <= '0;
      ref_r <= '0;
      hand_r <= '0;
    end else begin
      st_r <= st_nxt;
      vld_r <= vld_nxt;
      ref_r <= ref_nxt;
      hand_r <= hand_nxt;
    end
    req_r <= req_nxt;
    slot_r <= slot_nxt;
    hit_r <= hit_nxt;
    ev_r <= ev_nxt;
    evb_r <= evb_nxt;
    start_r <= start_nxt;
    fc_r <= fc_nxt;
    off_r <= off_nxt;
    inr_r <= inr_nxt;
  end

  // Tag store; entries are read only under their valid bit.
  always_ff @(posedge clk) begin
    if (tag_we) tag_r[slot_r] <= req_r.block_id;
  end

  // Sequencer: look up, walk on miss, then fill range and offset.
  always_comb begin
    st_nxt = st_r;
    vld_nxt = vld_r;
    ref_nxt = ref_r;
    hand_nxt = hand_r;
    req_nxt = req_r;
    slot_nxt = slot_r;
    hit_nxt = hit_r;
    ev_nxt = ev_r;
    evb_nxt = evb_r;
    start_nxt = start_r;
    fc_nxt = fc_r;
    off_nxt = off_r;
    inr_nxt = inr_r;
    tag_we = 1'b0;
    q_pop = 1'b0;
    unique case (st_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          req_nxt = q_data;
          st_nxt = BK_LOOK;
        end
      end
      BK_LOOK: begin
        start_nxt = prod[IdxW-1:0];
        inr_nxt = ({1'b0, req_r.record_index} < total_records);
        ev_nxt = 1'b0;
        evb_nxt = '0;
        if (any_match) begin
          hit_nxt = 1'b1;
          slot_nxt = match_idx;
          ref_nxt[match_idx] = 1'b1;
          st_nxt = BK_CALC;
        end else begin
          hit_nxt = 1'b0;
          st_nxt = BK_WALK;
        end
      end
      BK_WALK: begin
        // One hand step per cycle, clearing referenced bits.
        if (ref_r[hand_r]) begin
          ref_nxt[hand_r] = 1'b0;
          hand_nxt = hand_inc;
        end else begin
          slot_nxt = hand_r;
          hand_nxt = hand_inc;
          ev_nxt = vld_r[hand_r];
          evb_nxt = vld_r[hand_r] ? tag_r[hand_r] : '0;
          ref_nxt[hand_r] = 1'b1;
          vld_nxt[hand_r] = 1'b1;
          st_nxt = BK_CALC;
        end
      end
      BK_CALC: begin
        if (!hit_r) tag_we = 1'b1;
        fc_nxt = (hit_r || endc <= {2'b0, start_r}) ? '0
                 : BsW'(endc - {2'b0, start_r});
        st_nxt = BK_OFFS;
      end
      BK_OFFS: begin
        off_nxt = OffW'(sprod + (SW+BsW)'(req_r.record_index - start_r));
        st_nxt = BK_OUT;
      end
      BK_OUT: begin
        if (!out_stall) st_nxt = BK_IDLE;
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  assign out_valid = (st_r == BK_OUT);
  assign out_hit = hit_r;
  assign out_slot = 4'(slot_r);
  assign out_block_id = req_r.block_id;
  assign out_evict_valid = ev_r;
  assign out_evicted_block = evb_r;
  assign out_fill_first = hit_r ? '0 : start_r;
  assign out_fill_count = fc_r;
  assign out_storage_offset = inr_r ? off_r : '0;
  assign out_returned_length = inr_r ? record_length : '0;
endmodule

@@ rtl/clock_block_cache_controller_top.sv @@
// A hit's result passes through the divider, the queue handoff and the lookup, fill range,
// offset and output steps after its request is accepted.
// A miss adds a victim walk, in which the hand clears referenced slots (at most NUM_SLOTS)
// until it picks an unreferenced one. The front part stalls new requests while its divider
// is busy or its result waits on a full queue, while the back part drains the queue.
// Reset (synchronous, rst_n low): all slots invalid and unreferenced, hand at slot 0,
// block size 1, record total 0, record length 1.
module clock_block_cache_controller_top #(
  parameter int NUM_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [19:0] in_record_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [3:0]  out_slot,
  output logic [19:0] out_block_id,
  output logic        out_evict_valid,
  output logic [19:0] out_evicted_block,
  output logic [19:0] out_fill_first,
  output logic [8:0]  out_fill_count,
  output logic [11:0] out_storage_offset,
  output logic [15:0] out_returned_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_data
);
  import cbcc_pkg::*;

  logic [BsW-1:0]  bs_r;
  logic [TotW-1:0] tot_r;
  logic [LenW-1:0] len_r;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r <= 9'd1;
      tot_r <= '0;
      len_r <= 16'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgBlockSize:    bs_r <= cfg_data[BsW-1:0];
        CfgTotalRecords: tot_r <= cfg_data;
        CfgRecordLength: len_r <= cfg_data[LenW-1:0];
        default: ;
      endcase
    end
  end

  cbcc_req_t push_d, pop_d;
  logic push, full, pop, nempty;

  cbcc_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_record_index,
    .bs_cfg(bs_r), .q_push(push), .q_data(push_d), .q_full(full)
  );

  cbcc_queue u_queue (
    .clk, .rst_n, .push, .push_data(push_d), .full,
    .pop, .pop_data(pop_d), .not_empty(nempty)
  );

  cbcc_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
    .clk, .rst_n, .q_valid(nempty), .q_data(pop_d), .q_pop(pop),
    .total_records(tot_r), .record_length(len_r),
    .out_valid, .out_stall, .out_hit, .out_slot, .out_block_id,
    .out_evict_valid, .out_evicted_block, .out_fill_first, .out_fill_count,
    .out_storage_offset, .out_returned_length
  );

  // A hit never reports an eviction or a fill.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_evict_valid && out_fill_count == '0)
    else $error("hit with eviction or fill");

  // The queue is never pushed when full nor popped when empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full) && !(pop && !nempty))
    else $error("queue overflow or underflow");

  // A nonzero length only comes from a nonzero record length.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_returned_length != '0 |-> out_storage_offset <= 12'hFFF && len_r != '0)
    else $error("length without valid record length");
endmodule
